// ----- sv/i2cmra_pkg.sv -----
// i2cmra_pkg: shared types and constants for the i2c register access engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package i2cmra_pkg;
    // one tick word as classified by the front part
    typedef struct packed {
        logic       cmd_valid;
        logic       opcode;
        logic [7:0] device_address;
        logic [7:0] register_number;
        logic [7:0] write_value;
        logic [4:0] burst_length;
        logic       sda_sample;
    } t_tick;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       failed;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
    } t_res;

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_PS0  = 5'd1;
    localparam logic [4:0] PH_PS1  = 5'd2;
    localparam logic [4:0] PH_PS2  = 5'd3;
    localparam logic [4:0] PH_RS0  = 5'd4;
    localparam logic [4:0] PH_RS1  = 5'd5;
    localparam logic [4:0] PH_RS2  = 5'd6;
    localparam logic [4:0] PH_SP0  = 5'd7;
    localparam logic [4:0] PH_SP1  = 5'd8;
    localparam logic [4:0] PH_SP2  = 5'd9;
    localparam logic [4:0] PH_WB   = 5'd10;
    localparam logic [4:0] PH_RLO  = 5'd26;
    localparam logic [4:0] PH_RHI  = 5'd27;
    localparam logic [4:0] PH_MLO  = 5'd28;
    localparam logic [4:0] PH_MHI  = 5'd29;

    localparam logic [1:0] K_ADDR  = 2'd0;
    localparam logic [1:0] K_REG   = 2'd1;
    localparam logic [1:0] K_VAL   = 2'd2;
    localparam logic [1:0] K_RADDR = 2'd3;

    localparam logic       CFG_HALF  = 1'b0;
    localparam logic       CFG_RETRY = 1'b1;
endpackage
`default_nettype wire

// ----- sv/i2c_master_register_access.sv -----
// i2c_master_register_access: top level, front queue feeding the bus sequencer
// depends on i2cmra_pkg, i2cmra_front, i2cmra_back
//
// channel   dir  fields (tdata low bit up)
// s_axis    in   sda_sample, cmd_valid, opcode, device_address, register_number,
//                write_value, burst_length
// m_axis    out  scl_level, sda_release, busy_res, done_res, failed, read_valid,
//                read_byte, read_last
// cfg       in   index 0 half_period_ticks, 1 address_retry_limit
//
// one word per cycle sustained unless the output stalls; each word passes through the queue, then the result register
// sequencer state advances once per accepted word, one step per cycle unless stalled
// synchronous active-low reset clears state and sets registers to 50 and 100
// output stall fills the two-entry queue, then drops s_axis_tready
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_register_access #(
    parameter int MAX_BURST = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire [15:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [31:0]  s_axis_tdata,   // sda_sample, cmd_valid, opcode, addr, reg, val, len
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata    // scl, sda, busy, done, failed, rv, byte, last, pad
);
    import i2cmra_pkg::*;

    t_tick w_tick;
    t_res  w_res;
    logic  w_qv, w_qr;

    i2cmra_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_valid(w_qv), .i_ready(w_qr), .o_tick(w_tick)
    );

    i2cmra_back #(.MAX_BURST(MAX_BURST)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(w_qv), .o_ready(w_qr), .i_tick(w_tick),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {1'b0, w_res.read_last, w_res.read_byte, w_res.read_valid,
                           w_res.failed, w_res.done_res, w_res.busy_res,
                           w_res.sda_release, w_res.scl_level};

    a_fail_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.failed |-> w_res.done_res) else $error("fail without done");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.done_res |-> w_res.busy_res) else $error("done while idle");
    a_rd_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_res.read_valid |-> w_res.read_byte == 8'd0 && !w_res.read_last)
        else $error("stray read data");
endmodule
`default_nettype wire

// ----- sv/i2cmra_front.sv -----
// i2cmra_front: input stage and two-entry queue of tick words
// depends on i2cmra_pkg
`timescale 1ns / 1ps
`default_nettype none
module i2cmra_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [31:0]          i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output i2cmra_pkg::t_tick   o_tick
);
    import i2cmra_pkg::*;

    t_tick      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_tick      w_in;
    logic       w_push, w_pop;

    assign w_in.sda_sample      = i_data[0];
    assign w_in.cmd_valid       = i_data[1];
    assign w_in.opcode          = i_data[2];
    assign w_in.device_address  = i_data[10:3];
    assign w_in.register_number = i_data[18:11];
    assign w_in.write_value     = i_data[26:19];
    assign w_in.burst_length    = i_data[31:27];

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tick  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ----- sv/i2cmra_back.sv -----
// i2cmra_back: bus sequencer, one word/cycle unless stalled, registered result
// depends on i2cmra_pkg
`timescale 1ns / 1ps
`default_nettype none
module i2cmra_back #(
    parameter int MAX_BURST = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_idx,
    input  wire [15:0]          i_cfg_data,
    input  wire                 i_valid,
    output logic                o_ready,
    input  i2cmra_pkg::t_tick   i_tick,
    output logic                o_valid,
    input  wire                 i_ready,
    output i2cmra_pkg::t_res    o_res
);
    import i2cmra_pkg::*;

    logic [15:0] r_half;
    logic [7:0]  r_lim;
    logic [4:0]  r_ph, n_ph;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_sh, n_sh;
    logic [15:0] r_tk, n_tk;
    logic [7:0]  r_rt, n_rt;
    logic [4:0]  r_left, n_left;
    logic [7:0]  r_addr, n_addr, r_reg, n_reg, r_val, n_val;
    logic        r_rd, n_rd;
    logic        r_ov;
    t_res        r_res, n_res;
    logic        w_go;

    assign o_ready = !r_ov || i_ready;
    assign w_go    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_comb begin
        logic [4:0]  ph;
        logic [4:0]  len;
        logic [4:0]  rel;
        logic [1:0]  kind, sub;
        logic [15:0] tk1;
        n_ph = r_ph; n_bit = r_bit; n_sh = r_sh; n_tk = r_tk; n_rt = r_rt;
        n_left = r_left; n_addr = r_addr; n_reg = r_reg; n_val = r_val;
        n_rd = r_rd;
        n_res = '0;
        n_res.scl_level = 1'b1;
        n_res.sda_release = 1'b1;
        tk1 = '0;
        ph = r_ph;
        len = ({27'd0, i_tick.burst_length} > 32'(MAX_BURST)) ? 5'(MAX_BURST)
                                                              : i_tick.burst_length;
        if (ph == PH_IDLE && i_tick.cmd_valid) begin
            n_rd = i_tick.opcode;
            n_addr = i_tick.device_address;
            n_reg = i_tick.register_number;
            n_val = i_tick.write_value;
            n_left = len;
            n_rt = '0; n_tk = '0; n_bit = '0;
            if (i_tick.opcode && len == 5'd0) begin
                n_res.busy_res = 1'b1;
                n_res.done_res = 1'b1;
            end else begin
                ph = PH_PS0;
            end
        end
        n_ph = ph;
        rel = ph - PH_WB;
        kind = rel[3:2];
        sub = rel[1:0];
        if (ph != PH_IDLE) begin
            n_res.busy_res = 1'b1;
            if (ph >= PH_WB && ph < PH_RLO) begin
                n_res.scl_level = sub[0];
                n_res.sda_release = sub[1] ? 1'b1 : n_sh[7];
            end else begin
                unique case (ph)
                    PH_PS0, PH_RS0, PH_RLO, PH_MLO: begin
                        n_res.scl_level = 1'b0; n_res.sda_release = 1'b1;
                    end
                    PH_PS2, PH_RS2, PH_SP1: begin
                        n_res.scl_level = 1'b1; n_res.sda_release = 1'b0;
                    end
                    PH_SP0: begin
                        n_res.scl_level = 1'b0; n_res.sda_release = 1'b0;
                    end
                    default: ;
                endcase
            end
            tk1 = n_tk + 16'd1;
            if (tk1 != r_half) begin
                n_tk = tk1;
            end else begin
                n_tk = '0;
                if (ph >= PH_WB && ph < PH_RLO) begin
                    if (sub == 2'd0 || sub == 2'd2) begin
                        n_ph = ph + 5'd1;
                    end else if (sub == 2'd1) begin
                        n_sh = {n_sh[6:0], 1'b0};
                        n_bit = n_bit + 4'd1;
                        n_ph = (n_bit >= 4'd8) ? ph + 5'd1 : ph - 5'd1;
                    end else if (kind == K_ADDR) begin
                        if (i_tick.sda_sample) n_ph = PH_PS0;
                        else begin
                            n_sh = n_reg; n_bit = '0; n_ph = PH_WB + 5'd4;
                        end
                    end else if (kind == K_REG) begin
                        if (i_tick.sda_sample) begin
                            n_res.done_res = 1'b1; n_res.failed = 1'b1;
                            n_ph = PH_IDLE;
                        end else if (n_rd) n_ph = PH_RS0;
                        else begin
                            n_sh = n_val; n_bit = '0; n_ph = PH_WB + 5'd8;
                        end
                    end else if (kind == K_VAL) begin
                        if (i_tick.sda_sample) begin
                            n_res.done_res = 1'b1; n_res.failed = 1'b1;
                            n_ph = PH_IDLE;
                        end else n_ph = PH_SP0;
                    end else begin
                        n_sh = '0; n_bit = '0; n_ph = PH_RLO;
                    end
                end else begin
                    unique case (ph)
                        PH_PS2: begin
                            n_rt = n_rt + 8'd1;
                            if (n_rt == r_lim) begin
                                n_res.done_res = 1'b1; n_res.failed = 1'b1;
                                n_ph = PH_IDLE;
                            end else begin
                                n_sh = n_addr; n_bit = '0; n_ph = PH_WB;
                            end
                        end
                        PH_RS2: begin
                            n_sh = n_addr + 8'd1; n_bit = '0;
                            n_ph = PH_WB + 5'd12;
                        end
                        PH_RHI: begin
                            n_sh = {n_sh[6:0], i_tick.sda_sample};
                            n_bit = n_bit + 4'd1;
                            if (n_bit >= 4'd8) begin
                                n_res.read_valid = 1'b1;
                                n_res.read_byte = n_sh;
                                n_res.read_last = (n_left <= 5'd1);
                                n_ph = PH_MLO;
                            end else n_ph = PH_RLO;
                        end
                        PH_MHI: n_ph = PH_SP0;
                        PH_SP2: begin
                            if (n_rd && n_left > 5'd1) begin
                                n_left = n_left - 5'd1;
                                n_reg = n_reg + 8'd1;
                                n_rt = '0;
                                n_ph = PH_PS0;
                            end else begin
                                if (n_rd) n_left = '0;
                                n_res.done_res = 1'b1;
                                n_ph = PH_IDLE;
                            end
                        end
                        PH_PS0, PH_PS1, PH_RS0, PH_RS1, PH_SP0, PH_SP1,
                        PH_RLO, PH_MLO: n_ph = ph + 5'd1;
                        default: n_ph = PH_IDLE;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_res <= n_res;
            r_bit <= n_bit; r_sh <= n_sh; r_tk <= n_tk; r_rt <= n_rt;
            r_left <= n_left; r_addr <= n_addr; r_reg <= n_reg; r_val <= n_val;
            r_rd <= n_rd;
        end
        if (!i_rst_n) begin
            r_half <= 16'd50;
            r_lim  <= 8'd100;
            r_ph   <= PH_IDLE;
            r_ov   <= 1'b0;
            r_bit <= '0; r_sh <= '0; r_tk <= '0; r_rt <= '0; r_left <= '0;
            r_addr <= '0; r_reg <= '0; r_val <= '0; r_rd <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HALF:  r_half <= i_cfg_data;
                    CFG_RETRY: r_lim  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (w_go) r_ph <= n_ph;
            if (w_go) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking bench for i2c_master_register_access, one bus tick per stream word
// depends on i2cmra_pkg and the block; a scoreboard class predicts every result word
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import i2cmra_pkg::*;

    class i2c_scoreboard;
        int unsigned half, rlim;
        int unsigned ph, bc, sh, tc, rc, bl, ha, hr, hv, isrd;
        t_res exp_q[$];
        int errors;
        int words_in, words_out, cmds, reads, fails;

        function void reset_state();
            half = 50; rlim = 100;
            ph = PH_IDLE; bc = 0; sh = 0; tc = 0; rc = 0; bl = 0;
            ha = 0; hr = 0; hv = 0; isrd = 0;
            errors = 0; words_in = 0; words_out = 0; cmds = 0; reads = 0; fails = 0;
        endfunction

        function void set_reg(logic idx, int unsigned v);
            if (idx == CFG_HALF) half = v & 16'hFFFF;
            else rlim = v & 8'hFF;
        endfunction

        function bit idle();
            return ph == PH_IDLE;
        endfunction

        function bit ack_slot();
            return ph >= PH_WB && ph < PH_RLO && ((ph - PH_WB) & 3) == 3;
        endfunction

        function void start_byte(int unsigned kind, int unsigned v);
            sh = v & 8'hFF; bc = 0; ph = PH_WB + kind * 4;
        endfunction

        function void note(t_tick t);
            t_res r;
            int unsigned len, sub, kind;
            r = '0; r.scl_level = 1; r.sda_release = 1;
            words_in++;
            if (ph == PH_IDLE && t.cmd_valid) begin
                len = t.burst_length;
                if (len > 16) len = 16;
                isrd = t.opcode; ha = t.device_address; hr = t.register_number;
                hv = t.write_value; bl = len; rc = 0; tc = 0; bc = 0;
                cmds++;
                if (isrd && len == 0) begin
                    r.busy_res = 1; r.done_res = 1;
                end else ph = PH_PS0;
            end
            if (ph != PH_IDLE) begin
                r.busy_res = 1;
                if (ph >= PH_WB && ph < PH_RLO) begin
                    sub = (ph - PH_WB) & 3;
                    r.scl_level = sub[0];
                    r.sda_release = (sub < 2) ? sh[7] : 1'b1;
                end else begin
                    case (ph)
                        PH_PS0, PH_RS0, PH_RLO, PH_MLO: begin
                            r.scl_level = 0; r.sda_release = 1;
                        end
                        PH_PS2, PH_RS2, PH_SP1: begin
                            r.scl_level = 1; r.sda_release = 0;
                        end
                        PH_SP0: begin
                            r.scl_level = 0; r.sda_release = 0;
                        end
                        default: ;
                    endcase
                end
                if (((tc + 1) & 16'hFFFF) != half) tc = (tc + 1) & 16'hFFFF;
                else begin
                    tc = 0;
                    if (ph >= PH_WB && ph < PH_RLO) begin
                        kind = (ph - PH_WB) >> 2;
                        sub = (ph - PH_WB) & 3;
                        if (sub == 0 || sub == 2) ph++;
                        else if (sub == 1) begin
                            sh = (sh << 1) & 8'hFF; bc++;
                            ph = (bc >= 8) ? ph + 1 : ph - 1;
                        end else if (kind == K_ADDR) begin
                            if (t.sda_sample) ph = PH_PS0;
                            else start_byte(K_REG, hr);
                        end else if (kind == K_REG) begin
                            if (t.sda_sample) begin
                                r.done_res = 1; r.failed = 1; ph = PH_IDLE;
                            end else if (isrd) ph = PH_RS0;
                            else start_byte(K_VAL, hv);
                        end else if (kind == K_VAL) begin
                            if (t.sda_sample) begin
                                r.done_res = 1; r.failed = 1; ph = PH_IDLE;
                            end else ph = PH_SP0;
                        end else begin
                            sh = 0; bc = 0; ph = PH_RLO;
                        end
                    end else begin
                        case (ph)
                            PH_PS2: begin
                                rc = (rc + 1) & 8'hFF;
                                if (rc == rlim) begin
                                    r.done_res = 1; r.failed = 1; ph = PH_IDLE;
                                end else start_byte(K_ADDR, ha);
                            end
                            PH_RS2: start_byte(K_RADDR, ha + 1);
                            PH_RHI: begin
                                sh = ((sh << 1) | t.sda_sample) & 8'hFF; bc++;
                                if (bc >= 8) begin
                                    r.read_valid = 1; r.read_byte = sh[7:0];
                                    r.read_last = (bl <= 1); ph = PH_MLO;
                                end else ph = PH_RLO;
                            end
                            PH_MHI: ph = PH_SP0;
                            PH_SP2: begin
                                if (isrd && bl > 1) begin
                                    bl--; hr = (hr + 1) & 8'hFF; rc = 0; ph = PH_PS0;
                                end else begin
                                    if (isrd) bl = 0;
                                    r.done_res = 1; ph = PH_IDLE;
                                end
                            end
                            PH_PS0, PH_PS1, PH_RS0, PH_RS1, PH_SP0, PH_SP1, PH_RLO,
                            PH_MLO: ph++;
                            default: ph = PH_IDLE;
                        endcase
                    end
                end
            end
            if (r.read_valid) reads++;
            if (r.failed) fails++;
            exp_q.push_back(r);
        endfunction

        function void check(t_res r);
            t_res e;
            words_out++;
            if (exp_q.size() == 0) begin
                $display("%0t unexpected result word %h", $time, r);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (r !== e) begin
                $display("%0t mismatch expected %h actual %h", $time, e, r);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_cfg_we, i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid, s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [15:0] m_axis_tdata;

    i2c_scoreboard sb;
    int src_idle, dst_stall, ack_pct, wd;

    i2c_master_register_access dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic logic [31:0] pack_tick(t_tick t);
        return {t.burst_length, t.write_value, t.register_number, t.device_address,
                t.opcode, t.cmd_valid, t.sda_sample};
    endfunction

    function automatic t_res unpack_res(logic [15:0] d);
        t_res r;
        r.scl_level   = d[0];
        r.sda_release = d[1];
        r.busy_res    = d[2];
        r.done_res    = d[3];
        r.failed      = d[4];
        r.read_valid  = d[5];
        r.read_byte   = d[13:6];
        r.read_last   = d[14];
        return r;
    endfunction

    task automatic send(input t_tick t);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_tick(t);
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(t);
    endtask

    function automatic t_tick make_tick(int cmd_pct, int max_len);
        t_tick t;
        t = '0;
        t.cmd_valid = ($urandom_range(99) < cmd_pct);
        t.opcode = 1'($urandom_range(1));
        t.device_address = 8'($urandom_range(255));
        t.register_number = 8'($urandom_range(255));
        t.write_value = 8'($urandom_range(255));
        t.burst_length = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
                         5'($urandom_range(max_len));
        if (sb.ack_slot()) t.sda_sample = ($urandom_range(99) >= ack_pct);
        else t.sda_sample = 1'($urandom_range(1));
        return t;
    endfunction

    // idle ticks until the engine is back at rest, then wait for all words
    task automatic drain();
        t_tick t;
        while (!sb.idle()) begin
            t = make_tick(0, 1);
            send(t);
        end
        s_axis_tvalid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] v);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // one command, then idle ticks until it ends
    task automatic run_cmd(input logic op, input logic [7:0] a, input logic [7:0] r,
                           input logic [7:0] v, input logic [4:0] len);
        t_tick t;
        t = make_tick(0, 1);
        t.cmd_valid = 1; t.opcode = op; t.device_address = a;
        t.register_number = r; t.write_value = v; t.burst_length = len;
        send(t);
        drain();
    endtask

    task automatic random_run(int n, int max_len);
        t_tick t;
        repeat (n) begin
            t = make_tick(sb.idle() ? 30 : 3, max_len);
            send(t);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_stall);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(unpack_res(m_axis_tdata));
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) wd <= 0;
        else wd <= wd + 1;
        if (wd > 5000) begin
            $display("i2c_master_register_access regression: fail");
            $finish;
        end
    end

    initial begin
        sb = new();
        sb.reset_state();
        src_idle = 0; dst_stall = 0; ack_pct = 85;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = CFG_HALF; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed: field extremes, both opcodes, clamp, zero length, nak paths
        cfg_write(CFG_HALF, 16'd1);
        cfg_write(CFG_RETRY, 16'd3);
        ack_pct = 100;
        run_cmd(1'b0, 8'h00, 8'h00, 8'h00, 5'd1);
        run_cmd(1'b0, 8'hFE, 8'hFF, 8'hFF, 5'd1);
        run_cmd(1'b0, 8'h5A, 8'h3C, 8'hA5, 5'd1);
        run_cmd(1'b1, 8'hFE, 8'hFF, 8'h00, 5'd2);
        run_cmd(1'b1, 8'hFF, 8'h10, 8'h00, 5'd1);
        run_cmd(1'b1, 8'h20, 8'h00, 8'h00, 5'd0);
        run_cmd(1'b1, 8'h40, 8'hF8, 8'h00, 5'd31);
        ack_pct = 0;
        run_cmd(1'b0, 8'h12, 8'h34, 8'h56, 5'd1);
        run_cmd(1'b1, 8'h12, 8'h34, 8'h56, 5'd1);
        ack_pct = 60;
        run_cmd(1'b0, 8'h80, 8'h81, 8'h82, 5'd1);
        run_cmd(1'b1, 8'h80, 8'h81, 8'h82, 5'd3);

        cfg_write(CFG_HALF, 16'd65535);
        cfg_write(CFG_RETRY, 16'd255);
        run_cmd(1'b1, 8'h00, 8'h00, 8'h00, 5'd0);
        run_cmd(1'b1, 8'hFE, 8'hFF, 8'hFF, 5'd0);

        ack_pct = 85;
        cfg_write(CFG_HALF, 16'd2);
        cfg_write(CFG_RETRY, 16'd255);
        random_run(150, 2);

        src_idle = 62;
        cfg_write(CFG_HALF, 16'd1);
        cfg_write(CFG_RETRY, 16'd1);
        random_run(150, 2);

        src_idle = 0; dst_stall = 62;
        cfg_write(CFG_HALF, 16'd3);
        cfg_write(CFG_RETRY, 16'd100);
        random_run(150, 2);

        src_idle = 22; dst_stall = 22; ack_pct = 70;
        cfg_write(CFG_HALF, 16'd1);
        cfg_write(CFG_RETRY, 16'd2);
        random_run(150, 2);

        src_idle = 0; dst_stall = 0;
        drain();
        $display("covered %0d ticks, %0d commands, %0d read bytes, %0d failed commands",
                 sb.words_in, sb.cmds, sb.reads, sb.fails);
        $display("bus timing from 1 to 65535 ticks, retry limits 1 to 255, with stalls");
        if (sb.errors == 0 && sb.exp_q.size() == 0)
            $display("i2c_master_register_access regression: pass");
        else
            $display("i2c_master_register_access regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ----- i2c_master_register_access.f -----
sv/i2cmra_pkg.sv
sv/i2cmra_front.sv
sv/i2cmra_back.sv
sv/i2c_master_register_access.sv
tb/tb.sv
